// File: hdl/world_to_screen_projection_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WTSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define WTSP_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define WTSP_ASSERT(lbl, prop, msg)
`define WTSP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: hdl/wtsp_pkg.sv
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared types and constants of the world-to-screen projection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wtsp_pkg;
	localparam int COEF_W = 32;
	localparam int SIZE_W = 15;
	localparam int QUOT_W = 32;
	localparam int CFG_W  = 64;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_ROW_X_A = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW_X_B = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW_Y_A = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROW_Y_B = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROW_W_A = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROW_W_B = 3'd5;
	localparam logic [IDX_W-1:0] REG_VP_W    = 3'd6;
	localparam logic [IDX_W-1:0] REG_VP_H    = 3'd7;

	localparam logic [CFG_W-1:0]  RST_ROW_X_A = 64'h0000_0000_0001_0000;
	localparam logic [CFG_W-1:0]  RST_ROW_X_B = 64'h0;
	localparam logic [CFG_W-1:0]  RST_ROW_Y_A = 64'h0001_0000_0000_0000;
	localparam logic [CFG_W-1:0]  RST_ROW_Y_B = 64'h0;
	localparam logic [CFG_W-1:0]  RST_ROW_W_A = 64'h0;
	localparam logic [CFG_W-1:0]  RST_ROW_W_B = 64'h0001_0000_0000_0000;
	localparam logic [SIZE_W-1:0] RST_VP_W    = 15'd1920;
	localparam logic [SIZE_W-1:0] RST_VP_H    = 15'd1080;

	typedef logic signed [COEF_W-1:0] coef_t;

	// one matrix row: a*x + b*y + c*z + d
	typedef struct packed {
		coef_t a;
		coef_t b;
		coef_t c;
		coef_t d;
	} row_t;

	typedef struct packed {
		logic valid;
		logic vis;
	} ctl_t;
endpackage
`default_nettype wire

// File: hdl/wtsp_clip.sv
// ----------------------------------------------------------------------------
// wtsp_clip
// Two stages: nine coefficient products, then floored sums per row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wtsp_clip #(
	parameter int FRAC_BITS = 16,
	parameter int CW = 2 * wtsp_pkg::COEF_W + 2 - FRAC_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    in_valid,
	input  wire wtsp_pkg::coef_t         wx,
	input  wire wtsp_pkg::coef_t         wy,
	input  wire wtsp_pkg::coef_t         wz,
	input  wire wtsp_pkg::row_t          row_x,
	input  wire wtsp_pkg::row_t          row_y,
	input  wire wtsp_pkg::row_t          row_w,
	output logic                         out_valid,
	output logic signed [CW-1:0]         cx,
	output logic signed [CW-1:0]         cy,
	output logic signed [CW-1:0]         cw
);
	localparam int PW = 2 * wtsp_pkg::COEF_W;
	localparam int FW = PW - FRAC_BITS;

	wtsp_pkg::coef_t         coef [3][3];
	wtsp_pkg::coef_t         trans [3];
	wtsp_pkg::coef_t         pts [3];
	logic signed [PW-1:0]    prod_s1 [3][3];
	logic signed [CW-1:0]    clip_s2 [3];
	logic                    valid_s1;
	logic                    valid_s2;

	always_comb begin
		coef[0][0] = row_x.a; coef[0][1] = row_x.b; coef[0][2] = row_x.c;
		coef[1][0] = row_y.a; coef[1][1] = row_y.b; coef[1][2] = row_y.c;
		coef[2][0] = row_w.a; coef[2][1] = row_w.b; coef[2][2] = row_w.c;
		trans[0] = row_x.d;
		trans[1] = row_y.d;
		trans[2] = row_w.d;
		pts[0] = wx;
		pts[1] = wy;
		pts[2] = wz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[r][k] <= coef[r][k] * pts[k];
				end
			end
		end
	end

	// arithmetic shift floors the products
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				clip_s2[r] <= $signed(
					{{(CW-FW){prod_s1[r][0][PW-1]}}, prod_s1[r][0][PW-1:FRAC_BITS]} +
					{{(CW-FW){prod_s1[r][1][PW-1]}}, prod_s1[r][1][PW-1:FRAC_BITS]} +
					{{(CW-FW){prod_s1[r][2][PW-1]}}, prod_s1[r][2][PW-1:FRAC_BITS]} +
					{{(CW-wtsp_pkg::COEF_W){trans[r][wtsp_pkg::COEF_W-1]}}, trans[r]});
			end
		end
	end

	assign out_valid = valid_s2;
	assign cx = clip_s2[0];
	assign cy = clip_s2[1];
	assign cw = clip_s2[2];
endmodule
`default_nettype wire

// File: hdl/wtsp_axis.sv
// ----------------------------------------------------------------------------
// wtsp_axis
// One screen axis: (c + w) * size scaled, divided by 2w with rounding,
// saturated. Restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "world_to_screen_projection_assert.svh"
module wtsp_axis #(
	parameter int FRAC_BITS = 16,
	parameter int CW = 2 * wtsp_pkg::COEF_W + 2 - FRAC_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire wtsp_pkg::ctl_t                 ctl_i,
	input  wire logic signed [CW-1:0]           c_i,
	input  wire logic signed [CW-1:0]           w_i,
	input  wire logic [wtsp_pkg::SIZE_W-1:0]    size_i,
	output wtsp_pkg::ctl_t                      ctl_o,
	output logic [wtsp_pkg::QUOT_W-1:0]         res_o
);
	localparam int QW   = wtsp_pkg::QUOT_W;
	localparam int MW   = CW + 1;
	localparam int NW   = MW + wtsp_pkg::SIZE_W;
	localparam int RW   = NW + FRAC_BITS + 1;
	localparam int CMPW = (RW > CW + QW + 1) ? RW : CW + QW + 1;

	logic [MW-1:0] n_sum;
	logic [MW-1:0] mag_s3;
	logic          neg_s3;
	logic [CW-1:0] w_s3, d_s3;
	logic [wtsp_pkg::SIZE_W-1:0] size_s3;
	wtsp_pkg::ctl_t ctl_s3, ctl_s4, ctl_s5;

	logic [NW-1:0] prod_s4;
	logic          neg_s4, neg_s5;
	logic [CW-1:0] w_s4, d_s4, d_s5;
	logic [RW-1:0] nr_s5;

	logic [CMPW-1:0] dsh;
	logic [CMPW-1:0] lim;

	logic [RW-1:0]   rem_s6 [QW+1];
	logic [QW-1:0]   q_s6   [QW+1];
	logic [CW-1:0]   d_s6   [QW+1];
	logic            neg_s6 [QW+1];
	logic            sat_s6 [QW+1];
	wtsp_pkg::ctl_t  ctl_s6 [QW+1];

	logic [QW-1:0]   res_s39;
	wtsp_pkg::ctl_t  ctl_s39;

	// stage 3: numerator sign and magnitude, divisor 2w
	assign n_sum = {c_i[CW-1], c_i} + {w_i[CW-1], w_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6[0] <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_i;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6[0] <= ctl_s5;
		end
	end

	assign dsh = CMPW'(d_s5) << (QW - 1);
	assign lim = neg_s5 ? dsh + CMPW'(d_s5) : dsh;

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3  <= n_sum[MW-1];
			mag_s3  <= n_sum[MW-1] ? (~n_sum + MW'(1)) : n_sum;
			w_s3    <= w_i;
			d_s3    <= {w_i[CW-2:0], 1'b0};
			size_s3 <= size_i;

			prod_s4 <= NW'(mag_s3) * NW'(size_s3);
			neg_s4  <= neg_s3;
			w_s4    <= w_s3;
			d_s4    <= d_s3;

			// rounding: add w before dividing by 2w
			nr_s5   <= RW'({prod_s4, {FRAC_BITS{1'b0}}}) + RW'(w_s4);
			neg_s5  <= neg_s4;
			d_s5    <= d_s4;

			rem_s6[0] <= nr_s5;
			q_s6[0]   <= '0;
			d_s6[0]   <= d_s5;
			neg_s6[0] <= neg_s5;
			sat_s6[0] <= CMPW'(nr_s5) >= lim;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		logic [CMPW-1:0] tk;
		logic [CMPW-1:0] diff;
		logic            ge;

		assign tk   = CMPW'(d_s6[j]) << K;
		assign ge   = CMPW'(rem_s6[j]) >= tk;
		assign diff = CMPW'(rem_s6[j]) - tk;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s6[j+1] <= '0;
			end else if (adv) begin
				ctl_s6[j+1] <= ctl_s6[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s6[j+1] <= ge ? diff[RW-1:0] : rem_s6[j];
				q_s6[j+1]   <= {q_s6[j][QW-2:0], ge};
				d_s6[j+1]   <= d_s6[j];
				neg_s6[j+1] <= neg_s6[j];
				sat_s6[j+1] <= sat_s6[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s39 <= '0;
		end else if (adv) begin
			ctl_s39 <= ctl_s6[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!ctl_s6[QW].vis) begin
				res_s39 <= '0;
			end else if (sat_s6[QW]) begin
				res_s39 <= neg_s6[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
			end else begin
				res_s39 <= neg_s6[QW] ? (~q_s6[QW] + QW'(1)) : q_s6[QW];
			end
		end
	end

	assign ctl_o = ctl_s39;
	assign res_o = res_s39;

	`WTSP_ASSERT_NEVER(a_hidden_zero, ctl_o.valid && !ctl_o.vis && res_o != '0, "hidden point with nonzero screen value")
	`WTSP_ASSERT(a_rem_below_div, ctl_s6[QW].valid && ctl_s6[QW].vis && !sat_s6[QW] |-> CMPW'(rem_s6[QW]) < CMPW'(d_s6[QW]), "division remainder not below divisor")
	`WTSP_ASSERT(a_hold_on_stall, !adv |=> $stable(ctl_o) && $stable(res_o), "output stage moved while stalled")
endmodule
`default_nettype wire

// File: hdl/world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Projects world points through a view-projection matrix onto the viewport.
//
// channel  dir  payload
// s_*      in   tdata[95:0] = world_x, world_y, world_z
// m_*      out  tdata[63:0] = screen_x, screen_y; tuser = visible
// cfg_*    in   write enable, register index, 64-bit data
//
// One point per cycle while m_tready does not stall the output; the 32-stage
// divider (one quotient bit per stage) follows the matrix and scaling stages.
// Reset clears all valid bits and loads the default matrix and viewport.
// A stall on m_tready holds the whole pipeline; bubbles pass while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [95:0]                   s_tdata,   // world_x, world_y, world_z
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [63:0]                        m_tdata,   // screen_x, screen_y
	output logic                               m_tuser,   // visible
	input  wire logic                          cfg_we,
	input  wire logic [wtsp_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [wtsp_pkg::CFG_W-1:0]    cfg_data
);
	localparam int CW = 2 * wtsp_pkg::COEF_W + 2 - FRAC_BITS;
	localparam logic [CW-2:0] VIS_THRESH = (CW-1)'((64'd1 << FRAC_BITS) / 64'd1000000);

	logic [wtsp_pkg::CFG_W-1:0]  row_x_a_q, row_x_b_q, row_y_a_q, row_y_b_q;
	logic [wtsp_pkg::CFG_W-1:0]  row_w_a_q, row_w_b_q;
	logic [wtsp_pkg::SIZE_W-1:0] vp_w_q, vp_h_q;
	logic [wtsp_pkg::SIZE_W-1:0] size_w, size_h;

	wtsp_pkg::row_t row_x, row_y, row_w;
	logic           adv;
	logic           clip_valid;
	logic signed [CW-1:0] cx, cy, cw;
	wtsp_pkg::ctl_t ctl_clip, ctl_x, ctl_y;
	logic [wtsp_pkg::QUOT_W-1:0] res_x, res_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_a_q <= wtsp_pkg::RST_ROW_X_A;
			row_x_b_q <= wtsp_pkg::RST_ROW_X_B;
			row_y_a_q <= wtsp_pkg::RST_ROW_Y_A;
			row_y_b_q <= wtsp_pkg::RST_ROW_Y_B;
			row_w_a_q <= wtsp_pkg::RST_ROW_W_A;
			row_w_b_q <= wtsp_pkg::RST_ROW_W_B;
			vp_w_q    <= wtsp_pkg::RST_VP_W;
			vp_h_q    <= wtsp_pkg::RST_VP_H;
		end else if (cfg_we) begin
			case (cfg_index)
				wtsp_pkg::REG_ROW_X_A: row_x_a_q <= cfg_data;
				wtsp_pkg::REG_ROW_X_B: row_x_b_q <= cfg_data;
				wtsp_pkg::REG_ROW_Y_A: row_y_a_q <= cfg_data;
				wtsp_pkg::REG_ROW_Y_B: row_y_b_q <= cfg_data;
				wtsp_pkg::REG_ROW_W_A: row_w_a_q <= cfg_data;
				wtsp_pkg::REG_ROW_W_B: row_w_b_q <= cfg_data;
				wtsp_pkg::REG_VP_W:    vp_w_q    <= cfg_data[wtsp_pkg::SIZE_W-1:0];
				wtsp_pkg::REG_VP_H:    vp_h_q    <= cfg_data[wtsp_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign row_x = {row_x_a_q[31:0], row_x_a_q[63:32], row_x_b_q[31:0], row_x_b_q[63:32]};
	assign row_y = {row_y_a_q[31:0], row_y_a_q[63:32], row_y_b_q[31:0], row_y_b_q[63:32]};
	assign row_w = {row_w_a_q[31:0], row_w_a_q[63:32], row_w_b_q[31:0], row_w_b_q[63:32]};

	// zero size behaves as one
	assign size_w = (vp_w_q == '0) ? wtsp_pkg::SIZE_W'(1) : vp_w_q;
	assign size_h = (vp_h_q == '0) ? wtsp_pkg::SIZE_W'(1) : vp_h_q;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	wtsp_clip #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.wx        (s_tdata[31:0]),
		.wy        (s_tdata[63:32]),
		.wz        (s_tdata[95:64]),
		.row_x     (row_x),
		.row_y     (row_y),
		.row_w     (row_w),
		.out_valid (clip_valid),
		.cx        (cx),
		.cy        (cy),
		.cw        (cw)
	);

	assign ctl_clip.valid = clip_valid;
	assign ctl_clip.vis   = !cw[CW-1] && (cw[CW-2:0] > VIS_THRESH);

	wtsp_axis #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl_i  (ctl_clip),
		.c_i    (cx),
		.w_i    (cw),
		.size_i (size_w),
		.ctl_o  (ctl_x),
		.res_o  (res_x)
	);

	wtsp_axis #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl_i  (ctl_clip),
		.c_i    (cy),
		.w_i    (cw),
		.size_i (size_h),
		.ctl_o  (ctl_y),
		.res_o  (res_y)
	);

	assign m_tvalid = ctl_x.valid && ctl_y.valid;
	assign m_tuser  = ctl_x.vis;
	assign m_tdata  = {res_y, res_x};
endmodule
`default_nettype wire
